// ===== rtl/core/sce_pkg.sv =====
// Shared types and constants for the serial command elevator controller.
`default_nettype none

package sce_pkg;

  localparam int ROOMS      = 6;
  localparam int LIGHTS_W   = 6;
  localparam int ROOM_IDX_W = (ROOMS > 1) ? $clog2(ROOMS) : 1;
  localparam int QDEPTH     = 2;

  localparam logic [7:0] CH_START  = 8'h40;
  localparam logic [7:0] CH_END    = 8'h23;
  localparam logic [7:0] CH_ROOM0  = 8'h41;
  localparam logic [7:0] CH_FLOOR0 = 8'h30;
  localparam logic [7:0] CH_FLOOR2 = 8'h32;

  typedef enum logic {
    OP_BYTE = 1'b0,
    OP_TICK = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    DIR_STOP = 2'd0,
    DIR_UP   = 2'd1,
    DIR_DOWN = 2'd2
  } dir_t;

  // Decoded command byte; all zero means no command held.
  typedef struct packed {
    logic                  valid;
    logic                  room_hit;
    logic [ROOM_IDX_W-1:0] room_idx;
    logic                  floor_hit;
    logic [1:0]            floor_val;
  } cmd_t;

  typedef struct packed {
    op_t        op;
    logic       is_start;
    logic       is_end;
    cmd_t       cmd;
    logic       overrun;
    logic [2:0] sensors;
  } item_t;

  typedef struct packed {
    logic empty;
    logic full;
  } q_status_t;

  typedef struct packed {
    logic [1:0]          target_floor;
    logic [1:0]          floor_seen;
    dir_t                motor_drive;
    logic [LIGHTS_W-1:0] room_lights;
  } result_t;

endpackage

`default_nettype wire

// ===== rtl/core/serial_command_elevator_controller_top.sv =====
// Top level of the serial command elevator and room-light controller.
`default_nettype none

// The block takes one input transfer per clock while the queue is not full and returns
// exactly one result transfer for each, in order. A serial byte (tuser low) drives the
// "@x#" frame parser, which toggles a room light or sets the target floor; a tick (tuser
// high) samples the floor photocells and updates the motor direction. An item is
// registered first in the two-entry queue between the classifying front end and the
// executing back end, then in the output register. The back end finishes one item per
// cycle while the output is ready, which sets the sustained rate of one item per clock;
// the input keeps accepting until two items wait in the queue behind a stalled output.

module serial_command_elevator_controller_top
  import sce_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [15:0] s_axis_tdata,  // rx_byte[7:0], overrun[8], floor_sensors[11:9]
  input  wire logic        s_axis_tuser,  // opcode
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [15:0]      m_axis_tdata   // room_lights[5:0], motor_drive[7:6],
                                          // floor_seen[9:8], target_floor[11:10]
);

  logic      push;
  item_t     push_item;
  logic      pop;
  item_t     head;
  q_status_t q_st;

  sce_front u_front (
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .q_st          (q_st),
    .push          (push),
    .push_item     (push_item)
  );

  sce_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .head      (head),
    .q_st      (q_st)
  );

  sce_back u_back (
    .clk           (clk),
    .rst           (rst),
    .head          (head),
    .q_st          (q_st),
    .pop           (pop),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    pop |-> !q_st.empty)
    else $error("Back end took an item from an empty queue.");

  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    q_st.empty |-> s_axis_tready)
    else $error("Input stalled while the queue was empty.");

  a_motor_code: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> m_axis_tdata[7:6] != 2'd3)
    else $error("Invalid motor drive code on a result transfer.");

  a_pop_fills_output: assert property (@(posedge clk) disable iff (rst)
    pop |=> m_axis_tvalid)
    else $error("A processed item did not reach the output register.");

endmodule

`default_nettype wire

// ===== rtl/core/sce_front.sv =====
// Front end: accepts input transfers and classifies each byte before queuing it.
`default_nettype none

module sce_front
  import sce_pkg::*;
(
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [15:0] s_axis_tdata,  // rx_byte[7:0], overrun[8], floor_sensors[11:9]
  input  wire logic        s_axis_tuser,  // opcode
  input  wire q_status_t   q_st,
  output logic             push,
  output item_t            push_item
);

  logic [7:0] rx_byte;
  logic [7:0] room_off;

  assign rx_byte       = s_axis_tdata[7:0];
  assign room_off      = rx_byte - CH_ROOM0;
  assign s_axis_tready = !rst && !q_st.full;
  assign push          = s_axis_tvalid && s_axis_tready;

  always_comb begin
    push_item                = '0;
    push_item.op             = op_t'(s_axis_tuser);
    push_item.overrun        = s_axis_tdata[8];
    push_item.sensors        = s_axis_tdata[11:9];
    push_item.is_start       = (rx_byte == CH_START);
    push_item.is_end         = (rx_byte == CH_END);
    push_item.cmd.valid      = (rx_byte != 8'd0);
    push_item.cmd.room_hit   = (rx_byte >= CH_ROOM0) && (room_off < 8'(ROOMS))
                               && (room_off < 8'(LIGHTS_W));
    push_item.cmd.room_idx   = room_off[ROOM_IDX_W-1:0];
    push_item.cmd.floor_hit  = (rx_byte >= CH_FLOOR0) && (rx_byte <= CH_FLOOR2);
    push_item.cmd.floor_val  = 2'(rx_byte - CH_FLOOR0 + 8'd1);
  end

endmodule

`default_nettype wire

// ===== rtl/core/sce_queue.sv =====
// Two-entry queue that decouples the front end from the back end.
`default_nettype none

module sce_queue
  import sce_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  push,
  input  wire item_t push_item,
  input  wire logic  pop,
  output item_t      head,
  output q_status_t  q_st
);

  localparam int PTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int CNT_W = $clog2(QDEPTH + 1);

  item_t             mem [QDEPTH];
  logic [PTR_W-1:0]  wr_ptr;
  logic [PTR_W-1:0]  rd_ptr;
  logic [CNT_W-1:0]  count;

  assign head       = mem[rd_ptr];
  assign q_st.empty = (count == '0);
  assign q_st.full  = (count == CNT_W'(QDEPTH));

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(QDEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(QDEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/sce_back.sv =====
// Back end: frame parser, light and floor commands, motor control and result register.
`default_nettype none

module sce_back
  import sce_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire item_t       head,
  input  wire q_status_t   q_st,
  output logic             pop,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [15:0]      m_axis_tdata  // room_lights[5:0], motor_drive[7:6],
                                         // floor_seen[9:8], target_floor[11:10]
);

  logic                frame_open, frame_open_next;
  cmd_t                held, held_next;
  logic [1:0]          bytes_in_frame, bytes_in_frame_next;
  logic [LIGHTS_W-1:0] lights, lights_next;
  logic [1:0]          desired, desired_next;
  logic [1:0]          last_floor, last_floor_next;
  logic [1:0]          cur_floor, cur_floor_next;
  dir_t                dir, dir_next;
  logic [1:0]          seen;
  result_t             res;

  assign pop          = !q_st.empty && (!m_axis_tvalid || m_axis_tready);
  assign m_axis_tdata = {{(16 - $bits(result_t)){1'b0}}, res};

  always_comb begin
    frame_open_next     = frame_open;
    held_next           = held;
    bytes_in_frame_next = bytes_in_frame;
    lights_next         = lights;
    desired_next        = desired;
    last_floor_next     = last_floor;
    cur_floor_next      = cur_floor;
    dir_next            = dir;
    seen                = 2'd0;
    if (head.op == OP_BYTE) begin
      if (head.overrun) begin
        held_next           = '0;
        frame_open_next     = 1'b0;
        bytes_in_frame_next = 2'd0;
      end
      if (head.is_start) begin
        frame_open_next     = 1'b1;
        held_next           = '0;
        bytes_in_frame_next = 2'd0;
      end else if (head.is_end) begin
        frame_open_next = 1'b0;
      end else if (frame_open_next) begin
        held_next           = head.cmd;
        bytes_in_frame_next = bytes_in_frame_next + 2'd1;
        if (bytes_in_frame_next > 2'd1) begin
          frame_open_next     = 1'b0;
          held_next           = '0;
          bytes_in_frame_next = 2'd0;
        end
      end
      if (!frame_open_next && held_next.valid) begin
        if (held_next.room_hit) begin
          lights_next = lights ^ (LIGHTS_W'(1) << held_next.room_idx);
        end else if (held_next.floor_hit) begin
          desired_next = held_next.floor_val;
        end
        held_next           = '0;
        bytes_in_frame_next = 2'd0;
      end
    end else begin
      if (last_floor < desired) begin
        dir_next = head.sensors[2] ? DIR_STOP : DIR_UP;
      end
      if (last_floor > desired) begin
        dir_next = head.sensors[0] ? DIR_STOP : DIR_DOWN;
      end
      if (cur_floor == desired) begin
        dir_next = DIR_STOP;
      end
      cur_floor_next = 2'd0;
      if (head.sensors[0]) begin
        cur_floor_next  = 2'd1;
        last_floor_next = 2'd1;
      end else if (head.sensors[1]) begin
        cur_floor_next  = 2'd2;
        last_floor_next = 2'd2;
      end else if (head.sensors[2]) begin
        cur_floor_next  = 2'd3;
        last_floor_next = 2'd3;
      end
      seen = cur_floor_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_open     <= 1'b0;
      held           <= '0;
      bytes_in_frame <= 2'd0;
      lights         <= '0;
      desired        <= 2'd0;
      last_floor     <= 2'd0;
      cur_floor      <= 2'd0;
      dir            <= DIR_STOP;
      m_axis_tvalid  <= 1'b0;
    end else begin
      if (pop) begin
        frame_open     <= frame_open_next;
        held           <= held_next;
        bytes_in_frame <= bytes_in_frame_next;
        lights         <= lights_next;
        desired        <= desired_next;
        last_floor     <= last_floor_next;
        cur_floor      <= cur_floor_next;
        dir            <= dir_next;
        m_axis_tvalid  <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      res.room_lights  <= lights_next;
      res.motor_drive  <= dir_next;
      res.floor_seen   <= seen;
      res.target_floor <= desired_next;
    end
  end

endmodule

`default_nettype wire
